[hdl/tbg_pkg.sv]
// Shared types and constants of the tone burst generator.
// Depends on nothing; the top level and its checker import it.
`timescale 1ns / 1ps

package tbg_pkg;

   // Register indexes of the configuration port (byte address is 4 * index).
   localparam logic REG_PERIOD_SCALE = 1'b0;
   localparam logic REG_CYCLE_SCALE  = 1'b1;

   localparam logic [15:0] PERIOD_SCALE_RESET = 16'd57600;
   localparam logic [15:0] CYCLE_SCALE_RESET  = 16'd50000;

   // Request kinds carried on req_tuser.
   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_START = 1'b1;

   // Status codes of a response.
   typedef enum logic [1:0] {
      STATUS_NONE      = 2'd0,
      STATUS_ACCEPTED  = 2'd1,
      STATUS_BUSY      = 2'd2,
      STATUS_BAD_FREQ  = 2'd3
   } status_type;

   // Response payload, highest bit first when packed into rsp_tdata.
   typedef struct packed {
      logic       note_done;
      status_type status;
      logic       busy_res;
      logic       beeper_level;
   } rsp_fields_type;

endpackage

[hdl/tone_burst_generator.sv]
// Tone burst generator: note setup through a shared bit-serial divider and tick-driven playback.
// Depends on tbg_pkg.
`timescale 1ns / 1ps
// Responses: a tick, a start while busy or a start with frequency below 8 responds in the cycle
//   after acceptance; any other start responds once its divisions on the shared divider end.
// Throughput: no request is taken while a response waits; a start holds the block for its
//   three divisions, one quotient bit per cycle on the single shared restoring divider.
// Reset is synchronous, active high: the note stops, the beeper goes low and both
//   configuration registers return to their power-on values.

module tone_burst_generator #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] frequency, [31:16] duration_ms
   input  logic        req_tuser,   // [0] action
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] beeper_level, [1] busy_res, [3:2] status,
                                    // [4] note_done, [7:5] zero
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tbg_pkg::*;

   localparam int CW    = COUNT_WIDTH;
   localparam int CNT_W = $clog2(COUNT_WIDTH + 1);
   localparam int WIDE  = COUNT_WIDTH + 20;

   // The sequencer walks through the three divisions of a start in turn.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_CDIV,
      ST_DIV_QUOT,
      ST_DIV_HALVES
   } state_type;

   state_type        state_ff, state_in;

   // Configuration registers.
   logic [15:0]      period_scale_ff, period_scale_in;
   logic [15:0]      cycle_scale_ff, cycle_scale_in;

   // Note state.
   logic             beeper_ff, beeper_in;
   logic             playing_ff, playing_in;
   logic [CW-1:0]    half_period_ff, half_period_in;
   logic [CW-1:0]    tick_ff, tick_in;
   logic [CW-1:0]    halves_ff, halves_in;

   // Operands captured at start and the first quotient, kept for the third division.
   logic [15:0]      freq_ff, freq_in;
   logic [15:0]      dur_ff, dur_in;
   logic [15:0]      cdiv_ff, cdiv_in;

   // Shared restoring divider: partial remainder, quotient shifting in as the dividend
   // shifts out, divisor and a bit counter.
   logic [15:0]      rem_ff, rem_in;
   logic [CW-1:0]    quo_ff, quo_in;
   logic [15:0]      divisor_ff, divisor_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Response register.
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_fields_type   rsp_data_ff, rsp_data_in;

   // Divider step.
   logic [16:0]      trial;
   logic [16:0]      diff;
   logic             fits;
   logic [15:0]      rem_step;
   logic [CW-1:0]    quo_step;
   logic             div_last;

   // Helpers for the constant multiplications by ten.
   logic [19:0]      dur_x10;
   logic [WIDE-1:0]  dur_x10_wide;
   logic [CW+3:0]    quo_ext;
   logic [CW+3:0]    quo_x10;

   logic             req_accept;
   logic             rsp_load;
   status_type       rsp_status;
   logic             rsp_done;
   logic             csr_write;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         REG_PERIOD_SCALE: csr_prdata = {16'h0000, period_scale_ff};
         REG_CYCLE_SCALE:  csr_prdata = {16'h0000, cycle_scale_ff};
         default:          csr_prdata = 32'h0000_0000;
      endcase
   end

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   assign trial    = {rem_ff, quo_ff[CW-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign fits     = trial >= {1'b0, divisor_ff};
   assign rem_step = fits ? diff[15:0] : trial[15:0];
   assign quo_step = {quo_ff[CW-2:0], fits};
   assign div_last = (cnt_ff == CNT_W'(1));

   // Duration times ten, reduced to the count width, is the third dividend.
   assign dur_x10      = {1'b0, dur_ff, 3'b000} + {3'b000, dur_ff, 1'b0};
   assign dur_x10_wide = WIDE'(dur_x10);
   // The third quotient times ten, reduced to the count width, is the half-cycle count.
   assign quo_ext      = (CW + 4)'(quo_step);
   assign quo_x10      = (quo_ext << 3) + (quo_ext << 1);

   always_comb begin
      state_in        = state_ff;
      period_scale_in = period_scale_ff;
      cycle_scale_in  = cycle_scale_ff;
      beeper_in       = beeper_ff;
      playing_in      = playing_ff;
      half_period_in  = half_period_ff;
      tick_in         = tick_ff;
      halves_in       = halves_ff;
      freq_in         = freq_ff;
      dur_in          = dur_ff;
      cdiv_in         = cdiv_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      divisor_in      = divisor_ff;
      cnt_in          = cnt_ff;
      rsp_load        = 1'b0;
      rsp_status      = STATUS_NONE;
      rsp_done        = 1'b0;

      if (csr_write) begin
         case (csr_paddr[2])
            REG_PERIOD_SCALE: period_scale_in = csr_pwdata[15:0];
            REG_CYCLE_SCALE:  cycle_scale_in  = csr_pwdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_load = 1'b1;
               if (req_tuser == ACTION_TICK) begin
                  // A tick advances a playing note; the beeper flips on the first tick
                  // of every half cycle.
                  if (playing_ff) begin
                     if (tick_ff == '0) begin
                        beeper_in = !beeper_ff;
                     end
                     if (tick_ff >= half_period_ff) begin
                        tick_in   = '0;
                        halves_in = halves_ff - CW'(1);
                        if (halves_ff == CW'(1)) begin
                           playing_in = 1'b0;
                           rsp_done   = 1'b1;
                        end
                     end else begin
                        tick_in = tick_ff + CW'(1);
                     end
                  end
               end else if (playing_ff) begin
                  rsp_status = STATUS_BUSY;
               end else if (req_tdata[15:3] == 13'd0) begin
                  // Frequency over eight is zero, so no period can be derived.
                  rsp_status = STATUS_BAD_FREQ;
               end else begin
                  // First division: cycle_scale / frequency.
                  rsp_load   = 1'b0;
                  freq_in    = req_tdata[15:0];
                  dur_in     = req_tdata[31:16];
                  rem_in     = '0;
                  quo_in     = CW'(cycle_scale_ff);
                  divisor_in = req_tdata[15:0];
                  cnt_in     = CNT_W'(CW);
                  state_in   = ST_DIV_CDIV;
               end
            end
         end

         ST_DIV_CDIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (div_last) begin
               if (quo_step == '0) begin
                  rsp_load   = 1'b1;
                  rsp_status = STATUS_BAD_FREQ;
                  state_in   = ST_IDLE;
               end else begin
                  // Second division: period_scale / (frequency / 8).
                  cdiv_in    = quo_step[15:0];
                  rem_in     = '0;
                  quo_in     = CW'(period_scale_ff);
                  divisor_in = {3'b000, freq_ff[15:3]};
                  cnt_in     = CNT_W'(CW);
                  state_in   = ST_DIV_QUOT;
               end
            end
         end

         ST_DIV_QUOT: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (div_last) begin
               if (quo_step < CW'(2)) begin
                  rsp_load   = 1'b1;
                  rsp_status = STATUS_BAD_FREQ;
                  state_in   = ST_IDLE;
               end else begin
                  // Nothing can reject the start from here on, so the period is kept now.
                  // Third division: (duration * 10) / first quotient.
                  half_period_in = quo_step - CW'(2);
                  rem_in         = '0;
                  quo_in         = dur_x10_wide[CW-1:0];
                  divisor_in     = cdiv_ff;
                  cnt_in         = CNT_W'(CW);
                  state_in       = ST_DIV_HALVES;
               end
            end
         end

         ST_DIV_HALVES: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (div_last) begin
               rsp_load   = 1'b1;
               rsp_status = STATUS_ACCEPTED;
               tick_in    = '0;
               halves_in  = quo_x10[CW-1:0];
               // A zero half-cycle count ends the note at once.
               if (quo_x10[CW-1:0] == '0) begin
                  playing_in = 1'b0;
                  rsp_done   = 1'b1;
               end else begin
                  playing_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // The response register is empty whenever a result is loaded.
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.beeper_level = beeper_in;
         rsp_data_in.busy_res     = playing_in;
         rsp_data_in.status       = rsp_status;
         rsp_data_in.note_done    = rsp_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         period_scale_ff <= PERIOD_SCALE_RESET;
         cycle_scale_ff  <= CYCLE_SCALE_RESET;
         beeper_ff       <= 1'b0;
         playing_ff      <= 1'b0;
         half_period_ff  <= '0;
         tick_ff         <= '0;
         halves_ff       <= '0;
         cnt_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         period_scale_ff <= period_scale_in;
         cycle_scale_ff  <= cycle_scale_in;
         beeper_ff       <= beeper_in;
         playing_ff      <= playing_in;
         half_period_ff  <= half_period_in;
         tick_ff         <= tick_in;
         halves_ff       <= halves_in;
         cnt_ff          <= cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      freq_ff     <= freq_in;
      dur_ff      <= dur_in;
      cdiv_ff     <= cdiv_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      divisor_ff  <= divisor_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[hdl/tbg_checker.sv]
// Port-level checks of the tone burst generator, bound to the top level.
// Depends on tbg_pkg and tone_burst_generator.
`timescale 1ns / 1ps

module tbg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic [7:0] rsp_tdata
);
   import tbg_pkg::*;

   rsp_fields_type rsp;
   assign rsp = rsp_tdata[4:0];

   // A waiting response blocks new requests.
   a_no_accept_while_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready while a response is pending");

   // The response register is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A finished note is no longer busy.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.note_done) |-> !rsp.busy_res)
      else $error("note done while still busy");

   // A start rejected for being busy leaves the note playing.
   a_busy_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp.status == STATUS_BUSY)) |-> (rsp.busy_res && !rsp.note_done))
      else $error("busy rejection without a playing note");

   // A bad frequency never starts or ends a note.
   a_bad_freq_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp.status == STATUS_BAD_FREQ)) |-> (!rsp.busy_res && !rsp.note_done))
      else $error("bad frequency changed the note state");

endmodule

bind tone_burst_generator tbg_checker u_tbg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tdata  (rsp_tdata)
);
